@@ design/crarc_pkg.sv @@
// Shared types and constants for the Catmull-Rom arc-length evaluator.
package crarc_pkg;

	localparam int SAMPLE_COUNT_DEF = 64;

	localparam logic [1:0] CFG_POINT_A = 2'd0;
	localparam logic [1:0] CFG_POINT_B = 2'd1;
	localparam logic [1:0] CFG_POINT_C = 2'd2;
	localparam logic [1:0] CFG_POINT_D = 2'd3;

	localparam logic [1:0] MODE_POINT = 2'd0;
	localparam logic [1:0] MODE_ARC   = 2'd1;
	localparam logic [1:0] MODE_BUILD = 2'd2;
	localparam logic [1:0] MODE_RSVD  = 2'd3;

	localparam logic [1:0] AXIS_X    = 2'd0;
	localparam logic [1:0] AXIS_LAST = 2'd2;

	localparam logic [4:0] EVAL_LAST = 5'd6;
	localparam logic [4:0] DIV_LAST  = 5'd15;
	localparam logic [4:0] SQRT_LAST = 5'd19;

	typedef enum logic [2:0] {
		EV_MUL3, EV_LO1, EV_HI1, EV_RND, EV_LO2, EV_HI2, EV_FIN
	} ev_step_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_START, OP_CALC_D, OP_SRCH_RD, OP_SRCH_CMP, OP_RD_LO, OP_RD_HI,
		OP_CAP_HI, OP_DIV_INT, OP_DIV_STEP,
		OP_SET_TLO, OP_SET_THI, OP_T_POS, OP_T_ZERO, OP_T_LO, OP_T_LOQ, OP_T_Q,
		OP_EVAL, OP_RB_INIT, OP_SQ, OP_SQRT_INIT, OP_SQRT_STEP, OP_RB_WR,
		OP_CLR_RES, OP_OUT
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_TPOS, ST_TZERO, ST_EVAL, ST_CALC_D, ST_SRCH, ST_SCMP,
		ST_RDLO, ST_RDHI, ST_CAPHI, ST_DIV, ST_SETLO, ST_SETHI,
		ST_DINT, ST_TLOQ, ST_TLO, ST_RB0, ST_RBINIT, ST_RBT, ST_SQ,
		ST_SQI, ST_SQRT, ST_RBWR, ST_CLR, ST_OUT
	} st_t;

	typedef enum logic [1:0] {
		RET_OUT, RET_RBINIT, RET_SQ
	} ret_t;

	typedef struct packed {
		dp_op_t     op;
		ev_step_t   step;
		logic [1:0] axis;
		logic       nr;
		logic       zero_total;
	} dp_cmd_t;

	typedef struct packed {
		logic valid;
		logic srch_done;
		logic idx_zero;
		logic interp_ok;
		logic k_last;
		logic out_full;
	} dp_sts_t;

endpackage

@@ design/crarc_ctrl.sv @@
// Sequencer that steps the datapath through evaluation, search and rebuild.
module crarc_ctrl import crarc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] mode,
	input  logic       m_tready,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd
);

	st_t        st_q, st_d, dret_q, dret_d;
	ret_t       ret_q, ret_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] axis_q, axis_d;
	logic [1:0] mode_q, mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			dret_q <= ST_IDLE;
			ret_q  <= RET_OUT;
			cnt_q  <= '0;
			axis_q <= AXIS_X;
			mode_q <= MODE_POINT;
		end else begin
			st_q   <= st_d;
			dret_q <= dret_d;
			ret_q  <= ret_d;
			cnt_q  <= cnt_d;
			axis_q <= axis_d;
			mode_q <= mode_d;
		end
	end

	always_comb begin
		st_d           = st_q;
		dret_d         = dret_q;
		ret_d          = ret_q;
		cnt_d          = cnt_q;
		axis_d         = axis_q;
		mode_d         = mode_q;
		s_tready       = 1'b0;
		cmd.op         = OP_NOP;
		cmd.step       = EV_MUL3;
		cmd.axis       = axis_q;
		cmd.nr         = 1'b0;
		cmd.zero_total = 1'b0;
		case (st_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op = OP_START;
					mode_d = mode;
					case (mode)
						MODE_POINT: st_d = ST_TPOS;
						MODE_ARC:   st_d = sts.valid ? ST_CALC_D : ST_OUT;
						MODE_BUILD: st_d = ST_RB0;
						default:    st_d = ST_OUT;
					endcase
				end
			end
			ST_TPOS: begin
				cmd.op = OP_T_POS;
				ret_d  = RET_OUT;
				cnt_d  = '0;
				axis_d = AXIS_X;
				st_d   = ST_EVAL;
			end
			ST_TZERO: begin
				cmd.op = OP_T_ZERO;
				ret_d  = RET_OUT;
				cnt_d  = '0;
				axis_d = AXIS_X;
				st_d   = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.op   = OP_EVAL;
				cmd.step = ev_step_t'(cnt_q[2:0]);
				if (cnt_q == EVAL_LAST) begin
					cnt_d = '0;
					if (axis_q == AXIS_LAST) begin
						axis_d = AXIS_X;
						case (ret_q)
							RET_RBINIT: st_d = ST_RBINIT;
							RET_SQ:     st_d = ST_SQ;
							default:    st_d = ST_OUT;
						endcase
					end else begin
						axis_d = axis_q + 2'd1;
					end
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_CALC_D: begin
				cmd.op = OP_CALC_D;
				st_d   = ST_SRCH;
			end
			ST_SRCH: begin
				if (sts.srch_done) begin
					st_d = sts.idx_zero ? ST_TZERO : ST_RDLO;
				end else begin
					cmd.op = OP_SRCH_RD;
					st_d   = ST_SCMP;
				end
			end
			ST_SCMP: begin
				cmd.op = OP_SRCH_CMP;
				st_d   = ST_SRCH;
			end
			ST_RDLO: begin
				cmd.op = OP_RD_LO;
				st_d   = ST_RDHI;
			end
			ST_RDHI: begin
				cmd.op = OP_RD_HI;
				st_d   = ST_CAPHI;
			end
			ST_CAPHI: begin
				cmd.op = OP_CAP_HI;
				st_d   = ST_SETLO;
			end
			ST_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (cnt_q == DIV_LAST) begin
					cnt_d = '0;
					st_d  = dret_q;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_SETLO: begin
				cmd.op = OP_SET_TLO;
				st_d   = ST_SETHI;
			end
			ST_SETHI: begin
				cmd.op = OP_SET_THI;
				st_d   = sts.interp_ok ? ST_DINT : ST_TLO;
			end
			ST_DINT: begin
				cmd.op = OP_DIV_INT;
				cnt_d  = '0;
				dret_d = ST_TLOQ;
				st_d   = ST_DIV;
			end
			ST_TLOQ: begin
				cmd.op = OP_T_LOQ;
				ret_d  = RET_OUT;
				cnt_d  = '0;
				axis_d = AXIS_X;
				st_d   = ST_EVAL;
			end
			ST_TLO: begin
				cmd.op = OP_T_LO;
				ret_d  = RET_OUT;
				cnt_d  = '0;
				axis_d = AXIS_X;
				st_d   = ST_EVAL;
			end
			ST_RB0: begin
				cmd.op = OP_T_ZERO;
				ret_d  = RET_RBINIT;
				cnt_d  = '0;
				axis_d = AXIS_X;
				st_d   = ST_EVAL;
			end
			ST_RBINIT: begin
				cmd.op = OP_RB_INIT;
				st_d   = ST_RBT;
			end
			ST_RBT: begin
				cmd.op = OP_T_Q;
				ret_d  = RET_SQ;
				cnt_d  = '0;
				axis_d = AXIS_X;
				st_d   = ST_EVAL;
			end
			ST_SQ: begin
				cmd.op = OP_SQ;
				if (axis_q == AXIS_LAST) begin
					axis_d = AXIS_X;
					st_d   = ST_SQI;
				end else begin
					axis_d = axis_q + 2'd1;
				end
			end
			ST_SQI: begin
				cmd.op = OP_SQRT_INIT;
				cnt_d  = '0;
				st_d   = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				if (cnt_q == SQRT_LAST) begin
					cnt_d = '0;
					st_d  = ST_RBWR;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_RBWR: begin
				cmd.op = OP_RB_WR;
				st_d   = sts.k_last ? ST_CLR : ST_RBT;
			end
			ST_CLR: begin
				cmd.op = OP_CLR_RES;
				st_d   = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_full || m_tready) begin
					cmd.op         = OP_OUT;
					cmd.nr         = (mode_q == MODE_ARC) && !sts.valid;
					cmd.zero_total = (mode_q == MODE_RSVD);
					st_d           = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

endmodule

@@ design/crarc_dp.sv @@
// Datapath: control points, shared multiplier, divider, square root and length table.
module crarc_dp import crarc_pkg::*; #(
	parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_data,
	input  logic [15:0]        position,
	input  logic               m_tready,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	output logic               out_valid,
	output logic signed [17:0] out_x,
	output logic signed [17:0] out_y,
	output logic signed [17:0] out_z,
	output logic [23:0]        total_length,
	output logic               not_ready
);

	localparam int IW = $clog2(SAMPLE_COUNT);
	localparam logic [IW-1:0] LAST_IDX = IW'(SAMPLE_COUNT - 1);
	// Sample parameters k * 65536 / SAMPLE_COUNT come from a reciprocal multiply,
	// which is exact for every k below SAMPLE_COUNT with this shift.
	localparam int RSH = 2 * IW;
	localparam int MW  = IW + 18;
	localparam int PW  = IW + MW;
	localparam longint unsigned RECIP_L =
		((64'd1 << (RSH + 16)) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT);
	localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

	logic [47:0] pa_q, pb_q, pc_q, pd_q;
	logic [15:0] pos_q, t_q, tlo_q, thi_q;
	logic [23:0] total_q, d_q, len_lo_q, len_hi_q, run_q, rd_q;
	logic        valid_q;
	logic [IW-1:0] lo_q, hi_q, k_q;
	logic signed [59:0] acc_q;
	logic [39:0] tmp_q;
	logic signed [17:0] res_q [3];
	logic signed [17:0] prev_q [3];
	logic [39:0] sq_q, sv_q, sr_q, sbit_q;
	logic [24:0] rem_q;
	logic [15:0] nsh_q, quo_q;
	logic [23:0] den_q;
	logic [23:0] mem [SAMPLE_COUNT];

	function automatic logic signed [15:0] coord(input logic [47:0] p, input logic [1:0] ax);
		case (ax)
			2'd0:    coord = p[15:0];
			2'd1:    coord = p[31:16];
			default: coord = p[47:32];
		endcase
	endfunction

	logic signed [20:0] ca, cb, cc, cd, k1, k2, k3, mop;
	logic signed [16:0] tm;
	logic signed [37:0] prod;
	logic signed [59:0] rnd, sum_lo;
	logic [IW:0]   mid_sum;
	logic [IW-1:0] mid, rd_addr, samp_k;
	logic [PW-1:0] samp_prod;
	logic [15:0]   samp_t;
	logic [39:0]   dprod, inum;
	logic [24:0]   trial;
	logic signed [18:0] df;
	logic signed [37:0] dsq;
	logic [39:0]   s_try, s_r;
	logic [24:0]   run_sum;
	logic [23:0]   run_new;
	logic [20:0]   root;

	assign ca = 21'(coord(pa_q, cmd.axis));
	assign cb = 21'(coord(pb_q, cmd.axis));
	assign cc = 21'(coord(pc_q, cmd.axis));
	assign cd = 21'(coord(pd_q, cmd.axis));
	assign k1 = cc - ca;
	assign k2 = (ca <<< 1) - (cb <<< 2) - cb + (cc <<< 2) - cd;
	assign k3 = cd - ca + (cb <<< 1) + cb - (cc <<< 1) - cc;
	assign tm = signed'({1'b0, t_q});

	always_comb begin
		case (cmd.step)
			EV_MUL3:         mop = k3;
			EV_LO1, EV_LO2:  mop = signed'({1'b0, acc_q[19:0]});
			default:         mop = signed'(tmp_q[39:19]) >>> 1;
		endcase
	end

	assign prod   = 38'(mop) * 38'(tm);
	assign sum_lo = 60'(prod);
	assign rnd    = (acc_q + (60'sd1 <<< 32)) >>> 33;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[IW:1];
	assign dprod   = 40'(pos_q) * 40'(total_q);
	assign inum    = 40'(d_q - len_lo_q) * 40'(thi_q - tlo_q);
	assign trial   = {rem_q[23:0], nsh_q[15]};

	always_comb begin
		case (cmd.op)
			OP_SET_TLO: samp_k = lo_q - IW'(1);
			OP_SET_THI: samp_k = lo_q;
			default:    samp_k = k_q;
		endcase
	end

	assign samp_prod = PW'(samp_k) * PW'(RECIP);
	assign samp_t    = samp_prod[RSH +: 16];

	assign df  = 19'(res_q[cmd.axis]) - 19'(prev_q[cmd.axis]);
	assign dsq = 38'(df) * 38'(df);
	assign s_try = sr_q + sbit_q;
	assign s_r   = sr_q >> 1;
	assign root  = 21'(sr_q) + ((sv_q > sr_q) ? 21'd1 : 21'd0);
	assign run_sum = {1'b0, run_q} + 25'(root);
	assign run_new = run_sum[24] ? 24'hFFFFFF : run_sum[23:0];

	always_comb begin
		case (cmd.op)
			OP_SRCH_RD: rd_addr = mid;
			OP_RD_LO:   rd_addr = lo_q - IW'(1);
			default:    rd_addr = lo_q;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (cmd.op == OP_RB_INIT) begin
			mem[0] <= '0;
		end else if (cmd.op == OP_RB_WR) begin
			mem[k_q] <= run_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q <= '0;
			pb_q <= '0;
			pc_q <= '0;
			pd_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POINT_A: pa_q <= cfg_data;
				CFG_POINT_B: pb_q <= cfg_data;
				CFG_POINT_C: pc_q <= cfg_data;
				default:     pd_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_START: begin
				pos_q <= position;
				for (int i = 0; i < 3; i++) res_q[i] <= '0;
			end
			OP_CALC_D: begin
				d_q  <= dprod[39:16];
				lo_q <= '0;
				hi_q <= LAST_IDX;
			end
			OP_SRCH_CMP: begin
				if (rd_q >= d_q) hi_q <= mid;
				else lo_q <= mid + IW'(1);
			end
			OP_RD_HI:  len_lo_q <= rd_q;
			OP_CAP_HI: len_hi_q <= rd_q;
			OP_DIV_INT: begin
				rem_q <= {1'b0, inum[39:16]};
				nsh_q <= inum[15:0];
				quo_q <= '0;
				den_q <= len_hi_q - len_lo_q;
			end
			OP_DIV_STEP: begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[14:0], 1'b0};
				end
				nsh_q <= {nsh_q[14:0], 1'b0};
			end
			OP_SET_TLO: tlo_q <= samp_t;
			OP_SET_THI: thi_q <= samp_t;
			OP_T_POS:   t_q <= pos_q;
			OP_T_ZERO:  t_q <= '0;
			OP_T_LO:    t_q <= tlo_q;
			OP_T_LOQ:   t_q <= tlo_q + quo_q;
			OP_T_Q:     t_q <= samp_t;
			OP_EVAL: begin
				case (cmd.step)
					EV_MUL3: acc_q <= sum_lo + (60'(k2) <<< 16);
					EV_LO1: begin
						tmp_q <= acc_q[39:0];
						acc_q <= sum_lo + (60'(k1) <<< 32);
					end
					EV_HI1, EV_HI2: acc_q <= acc_q + (sum_lo <<< 20);
					EV_RND: acc_q <= (acc_q + (60'sd1 <<< 15)) >>> 16;
					EV_LO2: begin
						tmp_q <= acc_q[39:0];
						acc_q <= sum_lo + (60'(cb) <<< 33);
					end
					default: begin
						if (rnd > 60'sd131071) res_q[cmd.axis] <= 18'sd131071;
						else if (rnd < -60'sd131072) res_q[cmd.axis] <= -18'sd131072;
						else res_q[cmd.axis] <= 18'(rnd);
					end
				endcase
			end
			OP_RB_INIT: begin
				run_q <= '0;
				k_q   <= IW'(1);
				for (int i = 0; i < 3; i++) prev_q[i] <= res_q[i];
			end
			OP_SQ: begin
				sq_q <= ((cmd.axis == AXIS_X) ? 40'd0 : sq_q) + 40'(unsigned'(dsq));
				prev_q[cmd.axis] <= res_q[cmd.axis];
			end
			OP_SQRT_INIT: begin
				sv_q   <= sq_q;
				sr_q   <= '0;
				sbit_q <= 40'd1 << 38;
			end
			OP_SQRT_STEP: begin
				if (sv_q >= s_try) begin
					sv_q <= sv_q - s_try;
					sr_q <= s_r + sbit_q;
				end else begin
					sr_q <= s_r;
				end
				sbit_q <= sbit_q >> 2;
			end
			OP_RB_WR: begin
				run_q <= run_new;
				k_q   <= k_q + IW'(1);
				if (k_q == LAST_IDX) total_q <= run_new;
			end
			OP_CLR_RES: begin
				for (int i = 0; i < 3; i++) res_q[i] <= '0;
			end
			OP_OUT: begin
				out_x        <= res_q[0];
				out_y        <= res_q[1];
				out_z        <= res_q[2];
				total_length <= (cmd.zero_total || !valid_q) ? 24'd0 : total_q;
				not_ready    <= cmd.nr;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.op == OP_RB_WR && k_q == LAST_IDX) valid_q <= 1'b1;
			if (cmd.op == OP_OUT) out_valid <= 1'b1;
			else if (m_tready) out_valid <= 1'b0;
		end
	end

	assign sts.valid     = valid_q;
	assign sts.srch_done = (lo_q == hi_q);
	assign sts.idx_zero  = (lo_q == '0);
	assign sts.interp_ok = (len_hi_q > len_lo_q) && (d_q > len_lo_q);
	assign sts.k_last    = (k_q == LAST_IDX);
	assign sts.out_full  = out_valid;

endmodule

@@ design/catmull_rom_arc_length_eval.sv @@
// Top level of the Catmull-Rom segment evaluator with arc-length lookup.
// The four control points are written through the cfg port; the user must write them
// only while the block is idle, which the block itself does not enforce. Each input word
// carries a mode in s_tuser and a position in s_tdata; each word produces exactly one
// output word with the point, the total length and a flag. Items are handled one at a
// time by a sequencer driving a shared datapath, and s_tready is high only while the
// sequencer is idle. A point evaluation runs through the accept, a setup step, seven
// multiply steps per axis on one multiplier and the output load. An arc-length query
// runs a binary search with a table read and a compare per step, a bit-serial divide for
// the interpolation and the evaluation. In a rebuild each sample needs an evaluation,
// three square steps and a 20-step square root. A reserved mode or a query before any
// rebuild goes straight to the output load.
// Reset clears the control points, the table-valid flag and the output valid flag; the
// table itself is filled only by a rebuild. A finished word waits in the output
// register while m_tready is low, and the next input word is accepted in the meantime;
// that word's result then waits until the register is free.
module catmull_rom_arc_length_eval import crarc_pkg::*; #(
	parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // position[15:0]
	input  logic [1:0]  s_tuser,  // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // out_x[17:0], out_y[35:18], out_z[53:36], total_length[77:54]
	output logic        m_tuser   // not_ready
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic signed [17:0] px, py, pz;
	logic [23:0] tot;

	crarc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	crarc_dp #(.SAMPLE_COUNT(SAMPLE_COUNT)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.position     (s_tdata),
		.m_tready     (m_tready),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (m_tvalid),
		.out_x        (px),
		.out_y        (py),
		.out_z        (pz),
		.total_length (tot),
		.not_ready    (m_tuser)
	);

	assign m_tdata = {2'b00, tot, pz, py, px};

endmodule
